FILE: hw/rtl/indexed_list_store_assert.svh
// ----------------------------------------------------------------------------
// indexed_list_store_assert.svh
// Assertion macros shared by the list store RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ILS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Types, op codes, status codes and sizes of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    // Store size and derived widths
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 7;
    localparam int WORD_W  = 32;
    localparam int CMP_W   = CNT_W + INDEX_W;

    // Op codes
    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_APPEND = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_REMOVE = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               op;
        logic [INDEX_W-1:0]       index;
        logic signed [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic [LEN_W-1:0]         length;
    } rsp_t;

    // Entry RAM access, one write and one read port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

FILE: hw/rtl/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ils_ram
    import ils_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          mem_req,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Request sequencer: range checks, length count and the entry shift loop.
// ----------------------------------------------------------------------------
`include "indexed_list_store_assert.svh"

module ils_ctrl
    import ils_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_take,
    output rsp_t              res,
    output mem_req_t          mem_req,
    input  logic [WORD_W-1:0] mem_rdata
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_RD_WAIT  = 6'b000010,
        S_REM_WAIT = 6'b000100,
        S_SHIFT    = 6'b001000,
        S_FINAL    = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              active_reg, active_next;
    logic              pend_reg, pend_next;
    logic              ins_reg, ins_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [1:0]        status_reg, status_next;

    logic                     accept;
    logic [CMP_W-1:0]         idx_cmp, cnt_cmp;
    logic                     idx_bad, full;
    logic [ADDR_W-1:0]        idx_a, cm1_a;
    logic [CNT_W-1:0]         cm1;
    logic [CNT_W+LEN_W-1:0]   len_ext;

    assign accept  = req_valid && req_ready;
    assign idx_cmp = {{CNT_W{1'b0}}, req.index};
    assign cnt_cmp = {{INDEX_W{1'b0}}, count_reg};
    assign idx_bad = idx_cmp >= cnt_cmp;
    assign full    = count_reg == CNT_W'(DEPTH);
    assign idx_a   = req.index[ADDR_W-1:0];
    assign cm1     = count_reg - CNT_W'(1);
    assign cm1_a   = cm1[ADDR_W-1:0];

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            active_reg <= active_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        end_reg    <= end_next;
        wa_reg     <= wa_next;
        idx_reg    <= idx_next;
        ins_reg    <= ins_next;
        value_reg  <= value_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_ptr_next = rd_ptr_reg;
        end_next    = end_reg;
        wa_next     = wa_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        pend_next   = pend_reg;
        ins_next    = ins_reg;
        value_next  = value_reg;
        data_next   = data_reg;
        status_next = status_reg;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    data_next   = '0;
                    status_next = ST_OK;
                    value_next  = req.value;
                    idx_next    = idx_a;
                    pend_next   = 1'b0;
                    active_next = 1'b0;
                    state_next  = S_DONE;
                    unique case (req.op)
                        OP_READ:
                        begin
                            if (idx_bad)
                            begin
                                status_next = ST_INDEX;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = idx_a;
                                state_next    = S_RD_WAIT;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (idx_bad)
                            begin
                                status_next = ST_INDEX;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = idx_a;
                                mem_req.wdata = req.value;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = count_reg[ADDR_W-1:0];
                                mem_req.wdata = req.value;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (idx_bad)
                            begin
                                status_next = ST_INDEX;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // walk down from the last entry to the index
                                rd_ptr_next = cm1_a;
                                end_next    = idx_a;
                                active_next = 1'b1;
                                ins_next    = 1'b1;
                                count_next  = count_reg + CNT_W'(1);
                                state_next  = S_SHIFT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (idx_bad)
                            begin
                                status_next = ST_INDEX;
                            end
                            else
                            begin
                                // fetch the removed word, then walk up to the end
                                mem_req.re    = 1'b1;
                                mem_req.raddr = idx_a;
                                rd_ptr_next   = idx_a + ADDR_W'(1);
                                end_next      = cm1_a;
                                active_next   = idx_a != cm1_a;
                                ins_next      = 1'b0;
                                count_next    = cm1;
                                state_next    = S_REM_WAIT;
                            end
                        end
                        default:
                        begin
                            // unused op codes answer ok with no change
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                data_next  = mem_rdata;
                state_next = S_DONE;
            end
            S_REM_WAIT:
            begin
                data_next  = mem_rdata;
                state_next = active_reg ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                // retire the word read last cycle
                if (pend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = wa_reg;
                    mem_req.wdata = mem_rdata;
                end
                if (active_reg)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = rd_ptr_reg;
                    pend_next     = 1'b1;
                    wa_next       = ins_reg ? rd_ptr_reg + ADDR_W'(1)
                                            : rd_ptr_reg - ADDR_W'(1);
                    if (rd_ptr_reg == end_reg)
                    begin
                        active_next = 1'b0;
                    end
                    else
                    begin
                        rd_ptr_next = ins_reg ? rd_ptr_reg - ADDR_W'(1)
                                              : rd_ptr_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ins_reg ? S_FINAL : S_DONE;
                end
            end
            S_FINAL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg;
                mem_req.wdata = value_reg;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready  = state_reg == S_IDLE;
    assign res_valid  = state_reg == S_DONE;
    assign len_ext    = {{LEN_W{1'b0}}, count_reg};
    assign res.data   = data_reg;
    assign res.status = status_reg;
    assign res.length = len_ext[LEN_W-1:0];

    // Checks
    `ILS_ASSERT_NOW(a_idle_quiet, state_reg == S_IDLE, !pend_reg && !active_reg,
        "shift loop still busy while idle")
    `ILS_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CNT_W'(DEPTH),
        "length count beyond store depth")
    `ILS_ASSERT_NEXT(a_append_count,
        accept && req.op == OP_APPEND && !full,
        count_reg == $past(count_reg) + CNT_W'(1),
        "append did not grow the length by one")
    `ILS_ASSERT_NOW(a_write_phase, mem_req.we,
        state_reg == S_IDLE || state_reg == S_SHIFT || state_reg == S_FINAL,
        "entry write outside a write phase")

endmodule

FILE: hw/rtl/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit words in a 64-entry store with a length
// count. Read waits for the registered read data of the entry RAM, and a
// refused request answers without touching the entries. Insert and remove
// move one entry per cycle through the single read and single write port
// of the entry RAM; insert then writes the new word at its index, and
// remove first fetches the removed word. A finished result waits in the
// sequencer until the response register takes it. A new request is taken
// only once the sequencer is idle; the response register lets it start the
// next request while the previous response waits to be taken. Entries need
// no clearing after reset.
// ----------------------------------------------------------------------------
module indexed_list_store
    import ils_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    mem_req_t          mem_req;
    logic [WORD_W-1:0] mem_rdata;
    logic              res_valid;
    logic              res_take;
    rsp_t              res;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    ils_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    // Response register: load when empty or being drained
    assign res_take = res_valid && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
